// ===== hw/rtl/framed_uart_command_receiver_macros.svh =====
// Assertion macros shared by the frame receiver RTL.
`ifndef FRAMED_UART_COMMAND_RECEIVER_MACROS_SVH
`define FRAMED_UART_COMMAND_RECEIVER_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define FCR_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Overlapping implication checked outside reset.
`define FCR_ASSERT_IMPL(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define FCR_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/fcr_pkg.sv =====
// Types, constants and helper functions of the framed command receiver.
package fcr_pkg;

   // Frame and payload sizing
   localparam int MAX_LEN = 16;
   localparam int CNT_W   = $clog2(MAX_LEN + 1);

   // Field widths
   localparam int BYTE_W      = 8;
   localparam int INT_W       = 16;
   localparam int FRAC_W      = 20;
   localparam int FDIG_W      = 3;
   localparam int ANGLE_W     = 32;
   localparam int CSR_IDX_W   = 2;
   localparam int FRAC_DIGITS = 6;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_START_BYTE     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_END_BYTE       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION_CODE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_CODE     = 2'd3;

   // Register reset values
   localparam logic [BYTE_W-1:0] START_BYTE_RST     = 8'hFF;
   localparam logic [BYTE_W-1:0] END_BYTE_RST       = 8'hFE;
   localparam logic [BYTE_W-1:0] DIRECTION_CODE_RST = 8'h01;
   localparam logic [BYTE_W-1:0] ANGLE_CODE_RST     = 8'h02;

   // Result kinds
   localparam logic KIND_DIRECTION = 1'b0;
   localparam logic KIND_ANGLE     = 1'b1;

   // Characters
   localparam logic [BYTE_W-1:0] CHAR_SPACE = 8'h20;
   localparam logic [BYTE_W-1:0] CHAR_TAB   = 8'h09;
   localparam logic [BYTE_W-1:0] CHAR_CR    = 8'h0D;
   localparam logic [BYTE_W-1:0] CHAR_PLUS  = 8'h2B;
   localparam logic [BYTE_W-1:0] CHAR_MINUS = 8'h2D;
   localparam logic [BYTE_W-1:0] CHAR_POINT = 8'h2E;
   localparam logic [BYTE_W-1:0] CHAR_ZERO  = 8'h30;
   localparam logic [BYTE_W-1:0] CHAR_NINE  = 8'h39;

   // Saturation limits
   localparam logic [INT_W-1:0]   INT_MAX = '1;
   localparam logic [ANGLE_W-1:0] POS_MAX = 32'h7FFF_FFFF;
   localparam logic [ANGLE_W-1:0] NEG_MIN = 32'h8000_0000;

   // floor(x * 2^16 / 10^6) == (x * RECIP_M) >> RECIP_SHIFT for x < 2^20
   localparam int RECIP_W     = 31;
   localparam int RECIP_SHIFT = 34;
   localparam logic [RECIP_W-1:0] RECIP_M = 31'd1125899907;
   localparam int PROD_W      = FRAC_W + RECIP_W;

   typedef enum logic [1:0] {
      PH_START = 2'd0,
      PH_FLAG  = 2'd1,
      PH_DATA  = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      NUM_WS   = 2'd0,
      NUM_INT  = 2'd1,
      NUM_FRAC = 2'd2,
      NUM_DONE = 2'd3
   } num_type;

   // Scale that brings a fraction of n digits up to six digits: 10^(6-n)
   function automatic logic [FRAC_W-1:0] frac_scale(input logic [FDIG_W-1:0] n);
      logic [FRAC_W-1:0] s;
      unique case (n)
         3'd0:    s = 20'd1000000;
         3'd1:    s = 20'd100000;
         3'd2:    s = 20'd10000;
         3'd3:    s = 20'd1000;
         3'd4:    s = 20'd100;
         3'd5:    s = 20'd10;
         default: s = 20'd1;
      endcase
      return s;
   endfunction

   // Space, tab, line feed, vertical tab, form feed, carriage return
   function automatic logic is_space(input logic [BYTE_W-1:0] c);
      return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
   endfunction

endpackage

// ===== hw/rtl/framed_uart_command_receiver.sv =====
// Framed command receiver: frame parser, decimal parser and result pipeline.
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  req     | req_valid, req_stall, req_rx_byte             | in
//  rsp     | rsp_valid, rsp_stall, rsp_result_kind,        | out
//          | rsp_direction_value, rsp_angle_value          |
//  csr     | csr_write, csr_index, csr_wdata               | in
//
// One byte is taken per cycle unless req_stall is high; it updates frame and number state.
// A result leaves three registers after its end byte: snapshot (fraction scaling
// multiply), reciprocal multiply, then add/negate/saturate into the output register.
// Reset (synchronous) restores the register defaults and empties all stages.
// Empty stages collapse while rsp_stall is high; req_stall rises only when the
// snapshot, multiply and output registers all hold results.
`include "framed_uart_command_receiver_macros.svh"

module framed_uart_command_receiver (
   input  logic                                clock,
   input  logic                                reset,
   // byte input
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [fcr_pkg::BYTE_W-1:0]          req_rx_byte,
   // result output
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_result_kind,
   output logic [fcr_pkg::BYTE_W-1:0]          rsp_direction_value,
   output logic signed [fcr_pkg::ANGLE_W-1:0]  rsp_angle_value,
   // register writes
   input  logic                                csr_write,
   input  logic [fcr_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [fcr_pkg::BYTE_W-1:0]          csr_wdata
);

   // Configuration registers
   logic [fcr_pkg::BYTE_W-1:0] start_byte_ff, end_byte_ff, dir_code_ff, angle_code_ff;

   // Frame and number state
   fcr_pkg::phase_type         phase_ff, phase_in;
   logic [fcr_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [fcr_pkg::BYTE_W-1:0] flag_ff, flag_in;
   logic [fcr_pkg::BYTE_W-1:0] first_ff, first_in;
   fcr_pkg::num_type           num_ff, num_in;
   logic                       neg_ff, neg_in;
   logic [fcr_pkg::INT_W-1:0]  int_ff, int_in;
   logic [fcr_pkg::FRAC_W-1:0] frac_ff, frac_in;
   logic [fcr_pkg::FDIG_W-1:0] fdig_ff, fdig_in;

   // Result pipeline
   logic                       a_valid_ff, b_valid_ff, o_valid_ff;
   logic                       a_kind_ff, b_kind_ff, o_kind_ff;
   logic [fcr_pkg::BYTE_W-1:0] a_dir_ff, b_dir_ff, o_dir_ff;
   logic                       a_neg_ff, b_neg_ff;
   logic [fcr_pkg::INT_W-1:0]  a_int_ff, b_int_ff;
   logic [fcr_pkg::FRAC_W-1:0] a_frac6_ff;
   logic [fcr_pkg::INT_W-1:0]  b_fq_ff;
   logic [fcr_pkg::ANGLE_W-1:0] o_angle_ff, o_angle_in;

   logic                       req_accept;
   logic                       emit, emit_kind;
   logic                       o_free, b_free, a_free;
   logic                       is_digit;
   logic [3:0]                 digit;
   logic [fcr_pkg::FRAC_W-1:0] int_x10;
   logic [fcr_pkg::FRAC_W+3:0] frac_x10;
   logic [2*fcr_pkg::FRAC_W-1:0] frac6_full;
   logic [fcr_pkg::PROD_W-1:0] fq_full;
   logic [fcr_pkg::ANGLE_W-1:0] mag;
   logic                       end_taken, o_dir_word, o_angle_word;

   // Handshake and stage movement; a stage loads when empty or draining
   assign o_free     = !o_valid_ff || !rsp_stall;
   assign b_free     = !b_valid_ff || o_free;
   assign a_free     = !a_valid_ff || b_free;
   assign req_stall  = !a_free;
   assign req_accept = req_valid && !req_stall;

   // Digit decode
   assign is_digit = (req_rx_byte >= fcr_pkg::CHAR_ZERO) && (req_rx_byte <= fcr_pkg::CHAR_NINE);
   assign digit    = req_rx_byte[3:0];
   assign int_x10  = {1'b0, int_ff, 3'b000} + {3'b000, int_ff, 1'b0} + {16'd0, digit};
   assign frac_x10 = {1'b0, frac_ff, 3'b000} + {3'b000, frac_ff, 1'b0} + {20'd0, digit};

   // Frame state machine with the incremental decimal parser
   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      flag_in   = flag_ff;
      first_in  = first_ff;
      num_in    = num_ff;
      neg_in    = neg_ff;
      int_in    = int_ff;
      frac_in   = frac_ff;
      fdig_in   = fdig_ff;
      emit      = 1'b0;
      emit_kind = fcr_pkg::KIND_DIRECTION;
      if (req_accept) begin
         unique case (phase_ff)
            fcr_pkg::PH_FLAG: begin
               flag_in  = req_rx_byte;
               phase_in = fcr_pkg::PH_DATA;
            end
            fcr_pkg::PH_DATA: begin
               if (req_rx_byte == end_byte_ff) begin
                  phase_in = fcr_pkg::PH_START;
                  if (flag_ff == dir_code_ff) begin
                     emit      = (count_ff <= fcr_pkg::CNT_W'(1));
                     emit_kind = fcr_pkg::KIND_DIRECTION;
                  end else if (flag_ff == angle_code_ff) begin
                     emit      = 1'b1;
                     emit_kind = fcr_pkg::KIND_ANGLE;
                  end
               end else if (count_ff < fcr_pkg::CNT_W'(fcr_pkg::MAX_LEN)) begin
                  if (count_ff == '0) begin
                     first_in = req_rx_byte;
                  end
                  count_in = count_ff + fcr_pkg::CNT_W'(1);
                  // decimal parser
                  unique case (num_ff)
                     fcr_pkg::NUM_WS: begin
                        priority if (fcr_pkg::is_space(req_rx_byte)) begin
                           num_in = fcr_pkg::NUM_WS;
                        end else if (req_rx_byte == fcr_pkg::CHAR_PLUS ||
                                     req_rx_byte == fcr_pkg::CHAR_MINUS) begin
                           neg_in = (req_rx_byte == fcr_pkg::CHAR_MINUS);
                           num_in = fcr_pkg::NUM_INT;
                        end else if (req_rx_byte == fcr_pkg::CHAR_POINT) begin
                           num_in = fcr_pkg::NUM_FRAC;
                        end else if (is_digit) begin
                           int_in = {12'd0, digit};
                           num_in = fcr_pkg::NUM_INT;
                        end else begin
                           num_in = fcr_pkg::NUM_DONE;
                        end
                     end
                     fcr_pkg::NUM_INT: begin
                        priority if (is_digit) begin
                           int_in = (int_x10 > {4'd0, fcr_pkg::INT_MAX}) ?
                                    fcr_pkg::INT_MAX : int_x10[fcr_pkg::INT_W-1:0];
                        end else if (req_rx_byte == fcr_pkg::CHAR_POINT) begin
                           num_in = fcr_pkg::NUM_FRAC;
                        end else begin
                           num_in = fcr_pkg::NUM_DONE;
                        end
                     end
                     fcr_pkg::NUM_FRAC: begin
                        if (is_digit) begin
                           if (fdig_ff < fcr_pkg::FDIG_W'(fcr_pkg::FRAC_DIGITS)) begin
                              frac_in = frac_x10[fcr_pkg::FRAC_W-1:0];
                              fdig_in = fdig_ff + fcr_pkg::FDIG_W'(1);
                           end
                        end else begin
                           num_in = fcr_pkg::NUM_DONE;
                        end
                     end
                     default: begin
                        num_in = fcr_pkg::NUM_DONE;
                     end
                  endcase
               end else begin
                  // payload overflow drops the frame
                  phase_in = fcr_pkg::PH_START;
               end
            end
            default: begin
               phase_in = fcr_pkg::PH_START;
               if (req_rx_byte == start_byte_ff) begin
                  phase_in = fcr_pkg::PH_FLAG;
                  count_in = '0;
                  num_in   = fcr_pkg::NUM_WS;
                  neg_in   = 1'b0;
                  int_in   = '0;
                  frac_in  = '0;
                  fdig_in  = '0;
               end
            end
         endcase
      end
   end

   // Fraction brought to six digits, then times 2^16 / 10^6 by reciprocal
   assign frac6_full = {{fcr_pkg::FRAC_W{1'b0}}, frac_ff} *
                       {{fcr_pkg::FRAC_W{1'b0}}, fcr_pkg::frac_scale(fdig_ff)};
   assign fq_full    = fcr_pkg::PROD_W'(a_frac6_ff) * fcr_pkg::PROD_W'(fcr_pkg::RECIP_M);

   // Magnitude, sign and saturation
   assign mag = {b_int_ff, b_fq_ff};
   always_comb begin
      if (b_kind_ff != fcr_pkg::KIND_ANGLE) begin
         o_angle_in = '0;
      end else if (b_neg_ff) begin
         o_angle_in = (mag >= fcr_pkg::NEG_MIN) ? fcr_pkg::NEG_MIN : (~mag + 32'd1);
      end else begin
         o_angle_in = (mag > fcr_pkg::POS_MAX) ? fcr_pkg::POS_MAX : mag;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         start_byte_ff <= fcr_pkg::START_BYTE_RST;
         end_byte_ff   <= fcr_pkg::END_BYTE_RST;
         dir_code_ff   <= fcr_pkg::DIRECTION_CODE_RST;
         angle_code_ff <= fcr_pkg::ANGLE_CODE_RST;
         phase_ff      <= fcr_pkg::PH_START;
         count_ff      <= '0;
         flag_ff       <= '0;
         first_ff      <= '0;
         num_ff        <= fcr_pkg::NUM_WS;
         neg_ff        <= 1'b0;
         int_ff        <= '0;
         frac_ff       <= '0;
         fdig_ff       <= '0;
         a_valid_ff    <= 1'b0;
         b_valid_ff    <= 1'b0;
         o_valid_ff    <= 1'b0;
      end else begin
         if (csr_write) begin
            unique case (csr_index)
               fcr_pkg::CSR_START_BYTE:     start_byte_ff <= csr_wdata;
               fcr_pkg::CSR_END_BYTE:       end_byte_ff   <= csr_wdata;
               fcr_pkg::CSR_DIRECTION_CODE: dir_code_ff   <= csr_wdata;
               default:                     angle_code_ff <= csr_wdata;
            endcase
         end
         phase_ff <= phase_in;
         count_ff <= count_in;
         flag_ff  <= flag_in;
         first_ff <= first_in;
         num_ff   <= num_in;
         neg_ff   <= neg_in;
         int_ff   <= int_in;
         frac_ff  <= frac_in;
         fdig_ff  <= fdig_in;
         if (a_free) begin
            a_valid_ff <= emit;
         end
         if (b_free) begin
            b_valid_ff <= a_valid_ff;
         end
         if (o_free) begin
            o_valid_ff <= b_valid_ff;
         end
      end
   end

   // Pipeline payload registers
   always_ff @(posedge clock) begin
      if (a_free) begin
         a_kind_ff  <= emit_kind;
         a_dir_ff   <= first_ff;
         a_neg_ff   <= neg_ff;
         a_int_ff   <= int_ff;
         a_frac6_ff <= frac6_full[fcr_pkg::FRAC_W-1:0];
      end
      if (b_free) begin
         b_kind_ff <= a_kind_ff;
         b_dir_ff  <= (a_kind_ff == fcr_pkg::KIND_DIRECTION) ? a_dir_ff : '0;
         b_neg_ff  <= a_neg_ff;
         b_int_ff  <= a_int_ff;
         b_fq_ff   <= fq_full[fcr_pkg::RECIP_SHIFT +: fcr_pkg::INT_W];
      end
      if (o_free) begin
         o_kind_ff  <= b_kind_ff;
         o_dir_ff   <= b_dir_ff;
         o_angle_ff <= o_angle_in;
      end
   end

   assign rsp_valid           = o_valid_ff;
   assign rsp_result_kind     = o_kind_ff;
   assign rsp_direction_value = o_dir_ff;
   assign rsp_angle_value     = o_angle_ff;

   // Checks
   assign end_taken    = req_accept && (phase_ff == fcr_pkg::PH_DATA) &&
                         (req_rx_byte == end_byte_ff);
   assign o_dir_word   = o_valid_ff && (o_kind_ff == fcr_pkg::KIND_DIRECTION);
   assign o_angle_word = o_valid_ff && (o_kind_ff == fcr_pkg::KIND_ANGLE);

   `FCR_ASSERT(a_fdig_max, fdig_ff <= fcr_pkg::FDIG_W'(fcr_pkg::FRAC_DIGITS), "too many digits")
   `FCR_ASSERT_NEXT(a_end_closes, end_taken, phase_ff == fcr_pkg::PH_START, "frame not closed")
   `FCR_ASSERT_NEXT(a_stage_a_moves, a_valid_ff && b_free, b_valid_ff, "snapshot word lost")
   `FCR_ASSERT_IMPL(a_dir_no_angle, o_dir_word, o_angle_ff == '0, "direction word has an angle")
   `FCR_ASSERT_IMPL(a_angle_no_dir, o_angle_word, o_dir_ff == '0, "angle word has a direction")

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the framed command receiver: directed rows, then random frames.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int PHASE_BYTES  = 150;
   localparam int SETTLE_TICKS = 8;

   // One result word as it leaves the block
   typedef struct packed {
      logic                        kind;
      logic [fcr_pkg::BYTE_W-1:0]  direction;
      logic [fcr_pkg::ANGLE_W-1:0] angle;
   } update_type;

   // One directed stimulus row; want is used only where typed is set
   typedef struct packed {
      logic [fcr_pkg::BYTE_W-1:0] rx;
      logic                       typed;
      update_type                 want;
   } stim_row_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [fcr_pkg::BYTE_W-1:0]    req_rx_byte = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic                          rsp_result_kind;
   logic [fcr_pkg::BYTE_W-1:0]    rsp_direction_value;
   logic signed [fcr_pkg::ANGLE_W-1:0] rsp_angle_value;
   logic                          csr_write = 1'b0;
   logic [fcr_pkg::CSR_IDX_W-1:0] csr_index = fcr_pkg::CSR_START_BYTE;
   logic [fcr_pkg::BYTE_W-1:0]    csr_wdata = '0;

   // Typed expectation that travels with the byte on the bus
   logic                          byte_typed = 1'b0;
   update_type                    byte_want = '0;

   // Idling off for the whole phase when set
   bit                            quiet = 1'b0;

   update_type                    expected_updates[$];
   logic [fcr_pkg::BYTE_W-1:0]    frame_bytes[$];
   int                            fail_count = 0;
   int                            cycle_count = 0;
   int                            direction_checked = 0;
   int                            angle_checked = 0;
   int                            bytes_sent = 0;

   // Register copies
   logic [fcr_pkg::BYTE_W-1:0]    cfg_start, cfg_end, cfg_dir, cfg_angle;

   // Frame and number state of the predictor
   fcr_pkg::phase_type            frame_state;
   logic [fcr_pkg::CNT_W-1:0]     stored_count;
   logic [fcr_pkg::BYTE_W-1:0]    flag_seen, first_byte;
   fcr_pkg::num_type              digit_state;
   logic                          neg_seen;
   logic [fcr_pkg::INT_W-1:0]     int_acc;
   logic [fcr_pkg::FRAC_W-1:0]    frac_acc;
   logic [fcr_pkg::FDIG_W-1:0]    frac_digits;

   stim_row_type directed_rows [26];

   framed_uart_command_receiver DUT (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_rx_byte         (req_rx_byte),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_direction_value (rsp_direction_value),
      .rsp_angle_value     (rsp_angle_value),
      .csr_write           (csr_write),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Timeout watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t ns: timeout with %0d updates outstanding", $time,
                  expected_updates.size());
         $display("Test completed with failures");
         $finish;
      end
   end

   // Result side back-pressure
   always @(negedge clock) begin
      rsp_stall <= !quiet && ($urandom_range(99) < 33);
   end

   function automatic void restart_number();
      digit_state = fcr_pkg::NUM_WS;
      neg_seen    = 1'b0;
      int_acc     = '0;
      frac_acc    = '0;
      frac_digits = '0;
   endfunction

   // Advance the receiver state by one byte; returns 1 when an update is due
   function automatic bit frame_decode(input logic [fcr_pkg::BYTE_W-1:0] b,
                                       output update_type upd);
      logic              is_digit;
      logic [3:0]        digit;
      int unsigned       wide;
      longint unsigned   scale, part, mag;
      upd      = '0;
      is_digit = (b >= fcr_pkg::CHAR_ZERO) && (b <= fcr_pkg::CHAR_NINE);
      digit    = b[3:0];
      case (frame_state)
         fcr_pkg::PH_FLAG: begin
            flag_seen   = b;
            frame_state = fcr_pkg::PH_DATA;
            return 1'b0;
         end
         fcr_pkg::PH_DATA: begin
            if (b == cfg_end) begin
               frame_state = fcr_pkg::PH_START;
               if (flag_seen == cfg_dir) begin
                  if (stored_count > 1) return 1'b0;
                  upd.kind      = fcr_pkg::KIND_DIRECTION;
                  upd.direction = first_byte;
                  return 1'b1;
               end
               if (flag_seen == cfg_angle) begin
                  // Q15.16: integer part shifted up, fraction scaled and truncated
                  scale = 1;
                  repeat (frac_digits) scale = scale * 10;
                  part = 64'(frac_acc);
                  part = (part << 16) / scale;
                  mag  = 64'(int_acc);
                  mag  = (mag << 16) + part;
                  upd.kind = fcr_pkg::KIND_ANGLE;
                  if (neg_seen)
                     upd.angle = (mag >= 64'h8000_0000) ? fcr_pkg::NEG_MIN :
                                 ~mag[31:0] + 32'd1;
                  else
                     upd.angle = (mag > 64'h7FFF_FFFF) ? fcr_pkg::POS_MAX : mag[31:0];
                  return 1'b1;
               end
               return 1'b0;
            end
            if (stored_count >= fcr_pkg::MAX_LEN) begin
               // payload overflow drops the frame
               frame_state = fcr_pkg::PH_START;
               return 1'b0;
            end
            if (stored_count == 0) first_byte = b;
            stored_count = stored_count + fcr_pkg::CNT_W'(1);
            // incremental decimal parse
            case (digit_state)
               fcr_pkg::NUM_WS: begin
                  if ((b == fcr_pkg::CHAR_SPACE) ||
                      ((b >= fcr_pkg::CHAR_TAB) && (b <= fcr_pkg::CHAR_CR))) begin
                     // leading whitespace skipped
                  end else if ((b == fcr_pkg::CHAR_PLUS) || (b == fcr_pkg::CHAR_MINUS)) begin
                     neg_seen    = (b == fcr_pkg::CHAR_MINUS);
                     digit_state = fcr_pkg::NUM_INT;
                  end else if (b == fcr_pkg::CHAR_POINT) begin
                     digit_state = fcr_pkg::NUM_FRAC;
                  end else if (is_digit) begin
                     int_acc     = fcr_pkg::INT_W'(digit);
                     digit_state = fcr_pkg::NUM_INT;
                  end else begin
                     digit_state = fcr_pkg::NUM_DONE;
                  end
               end
               fcr_pkg::NUM_INT: begin
                  if (is_digit) begin
                     wide    = 32'(int_acc) * 32'd10 + 32'(digit);
                     int_acc = (wide > 32'hFFFF) ? fcr_pkg::INT_MAX :
                               wide[fcr_pkg::INT_W-1:0];
                  end else if (b == fcr_pkg::CHAR_POINT) begin
                     digit_state = fcr_pkg::NUM_FRAC;
                  end else begin
                     digit_state = fcr_pkg::NUM_DONE;
                  end
               end
               fcr_pkg::NUM_FRAC: begin
                  if (is_digit) begin
                     if (frac_digits < fcr_pkg::FRAC_DIGITS) begin
                        frac_acc    = frac_acc * 20'd10 + fcr_pkg::FRAC_W'(digit);
                        frac_digits = frac_digits + fcr_pkg::FDIG_W'(1);
                     end
                  end else begin
                     digit_state = fcr_pkg::NUM_DONE;
                  end
               end
               default: begin
               end
            endcase
            return 1'b0;
         end
         default: begin
            frame_state = fcr_pkg::PH_START;
            if (b == cfg_start) begin
               frame_state  = fcr_pkg::PH_FLAG;
               stored_count = '0;
               restart_number();
            end
            return 1'b0;
         end
      endcase
   endfunction

   // Predict on accepted bytes, check accepted result words
   always @(posedge clock) begin : scoreboard
      update_type modeled, want;
      bit         produced;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            produced = frame_decode(req_rx_byte, modeled);
            if (byte_typed) begin
               if (!produced || (modeled != byte_want)) begin
                  $display("%0t ns: directed row, expected %h, predictor gives %h (due %0d)",
                           $time, byte_want, modeled, produced);
                  fail_count++;
               end
               expected_updates.push_back(byte_want);
            end else if (produced) begin
               expected_updates.push_back(modeled);
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_updates.size() == 0) begin
               $display("%0t ns: unexpected word, expected none, got kind %0d dir %0h angle %0d",
                        $time, rsp_result_kind, rsp_direction_value, rsp_angle_value);
               fail_count++;
            end else begin
               want = expected_updates.pop_front();
               if (rsp_result_kind !== want.kind) begin
                  $display("%0t ns: result_kind expected %0d, got %0d",
                           $time, want.kind, rsp_result_kind);
                  fail_count++;
               end
               if (rsp_direction_value !== want.direction) begin
                  $display("%0t ns: direction_value expected %0h, got %0h",
                           $time, want.direction, rsp_direction_value);
                  fail_count++;
               end
               if (rsp_angle_value !== want.angle) begin
                  $display("%0t ns: angle_value expected %0d, got %0d",
                           $time, $signed(want.angle), rsp_angle_value);
                  fail_count++;
               end
               if (want.kind == fcr_pkg::KIND_ANGLE) angle_checked++;
               else direction_checked++;
            end
         end
      end
   end

   // Present one byte with random idle cycles ahead of it, hold until taken
   task automatic send_byte(input logic [fcr_pkg::BYTE_W-1:0] b, input logic typed,
                            input update_type want);
      while (!quiet && ($urandom_range(99) < 33)) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      byte_typed  <= typed;
      byte_want   <= want;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
   endtask

   task automatic write_reg(input logic [fcr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [fcr_pkg::BYTE_W-1:0] val);
      @(negedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         fcr_pkg::CSR_START_BYTE:     cfg_start = val;
         fcr_pkg::CSR_END_BYTE:       cfg_end   = val;
         fcr_pkg::CSR_DIRECTION_CODE: cfg_dir   = val;
         default:                     cfg_angle = val;
      endcase
   endtask

   // Drain the block, then load a full register setting
   task automatic apply_setting(input logic [fcr_pkg::BYTE_W-1:0] s,
                                input logic [fcr_pkg::BYTE_W-1:0] e,
                                input logic [fcr_pkg::BYTE_W-1:0] d,
                                input logic [fcr_pkg::BYTE_W-1:0] a);
      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_updates.size() != 0) @(posedge clock);
      repeat (SETTLE_TICKS) @(posedge clock);
      write_reg(fcr_pkg::CSR_START_BYTE, s);
      write_reg(fcr_pkg::CSR_END_BYTE, e);
      write_reg(fcr_pkg::CSR_DIRECTION_CODE, d);
      write_reg(fcr_pkg::CSR_ANGLE_CODE, a);
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic logic [fcr_pkg::BYTE_W-1:0] payload_byte();
      logic [fcr_pkg::BYTE_W-1:0] b;
      do b = 8'($urandom); while (b == cfg_end);
      return b;
   endfunction

   // Build one random frame (or a burst of line noise) into q
   task automatic build_frame(ref logic [fcr_pkg::BYTE_W-1:0] q[$], output bit noise);
      int                         pick, n;
      logic [fcr_pkg::BYTE_W-1:0] c;
      logic                       closed;
      q.delete();
      noise  = 1'b0;
      closed = 1'b1;
      pick   = $urandom_range(99);
      if (pick >= 89 && pick < 95) begin
         noise = 1'b1;
         repeat ($urandom_range(1, 4)) q.push_back(8'($urandom));
         return;
      end
      q.push_back(cfg_start);
      if (pick < 45) begin
         // well-formed angle text with random content
         q.push_back(cfg_angle);
         repeat ($urandom_range(0, 2)) begin
            c = 8'($urandom_range(8, 13));
            q.push_back((c == 8'd8) ? fcr_pkg::CHAR_SPACE : c);
         end
         case ($urandom_range(2))
            1: q.push_back(fcr_pkg::CHAR_PLUS);
            2: q.push_back(fcr_pkg::CHAR_MINUS);
            default: ;
         endcase
         n = ($urandom_range(9) == 0) ? $urandom_range(6, 8) : $urandom_range(0, 5);
         repeat (n) q.push_back(fcr_pkg::CHAR_ZERO + 8'($urandom_range(9)));
         if ($urandom_range(9) < 7) begin
            q.push_back(fcr_pkg::CHAR_POINT);
            repeat ($urandom_range(0, 8))
               q.push_back(fcr_pkg::CHAR_ZERO + 8'($urandom_range(9)));
         end
         // trailing junk: exponent letter, hex marker, nul or anything
         if ($urandom_range(9) < 3) begin
            case ($urandom_range(3))
               0: q.push_back(8'h65);
               1: q.push_back(8'h78);
               2: q.push_back(8'h00);
               default: q.push_back(payload_byte());
            endcase
         end
         while (q.size() > fcr_pkg::MAX_LEN + 2) void'(q.pop_back());
      end else if (pick < 65) begin
         q.push_back(cfg_dir);
         if ($urandom_range(3) != 0) q.push_back(payload_byte());
      end else if (pick < 73) begin
         // long direction frame
         q.push_back(cfg_dir);
         repeat ($urandom_range(2, fcr_pkg::MAX_LEN)) q.push_back(payload_byte());
      end else if (pick < 79) begin
         // payload overflow
         q.push_back($urandom_range(1) ? cfg_dir : cfg_angle);
         repeat (fcr_pkg::MAX_LEN + 1 + $urandom_range(0, 2)) q.push_back(payload_byte());
      end else if (pick < 84) begin
         do c = 8'($urandom); while (c == cfg_dir || c == cfg_angle);
         q.push_back(c);
         repeat ($urandom_range(0, 4)) q.push_back(payload_byte());
      end else if (pick < 89) begin
         // flag equal to the start or end byte
         q.push_back($urandom_range(1) ? cfg_start : cfg_end);
         repeat ($urandom_range(0, 3)) q.push_back(payload_byte());
      end else begin
         // frame cut short, no end byte
         q.push_back($urandom_range(1) ? cfg_dir : cfg_angle);
         repeat ($urandom_range(0, 5)) q.push_back(payload_byte());
         closed = 1'b0;
      end
      if (closed) q.push_back(cfg_end);
   endtask

   task automatic random_phase();
      int count;
      bit noise;
      count = 0;
      while (count < PHASE_BYTES) begin
         build_frame(frame_bytes, noise);
         foreach (frame_bytes[i]) send_byte(frame_bytes[i], 1'b0, '0);
         if (!noise) count += frame_bytes.size();
      end
   endtask

   initial begin
      directed_rows = '{
         // empty direction frame right after reset reports zero
         '{fcr_pkg::START_BYTE_RST, 1'b0, '0},
         '{fcr_pkg::DIRECTION_CODE_RST, 1'b0, '0},
         '{fcr_pkg::END_BYTE_RST, 1'b1, '{fcr_pkg::KIND_DIRECTION, 8'h00, 32'h0}},
         // single payload byte equal to the start byte value
         '{fcr_pkg::START_BYTE_RST, 1'b0, '0},
         '{fcr_pkg::DIRECTION_CODE_RST, 1'b0, '0},
         '{8'hFF, 1'b0, '0},
         '{fcr_pkg::END_BYTE_RST, 1'b1, '{fcr_pkg::KIND_DIRECTION, 8'hFF, 32'h0}},
         // large negative integer saturates
         '{fcr_pkg::START_BYTE_RST, 1'b0, '0},
         '{fcr_pkg::ANGLE_CODE_RST, 1'b0, '0},
         '{fcr_pkg::CHAR_MINUS, 1'b0, '0},
         '{fcr_pkg::CHAR_NINE, 1'b0, '0},
         '{fcr_pkg::CHAR_NINE, 1'b0, '0},
         '{fcr_pkg::CHAR_NINE, 1'b0, '0},
         '{fcr_pkg::CHAR_NINE, 1'b0, '0},
         '{fcr_pkg::CHAR_NINE, 1'b0, '0},
         '{fcr_pkg::END_BYTE_RST, 1'b1, '{fcr_pkg::KIND_ANGLE, 8'h00, fcr_pkg::NEG_MIN}},
         // tab, plus sign, bare fraction
         '{fcr_pkg::START_BYTE_RST, 1'b0, '0},
         '{fcr_pkg::ANGLE_CODE_RST, 1'b0, '0},
         '{fcr_pkg::CHAR_TAB, 1'b0, '0},
         '{fcr_pkg::CHAR_PLUS, 1'b0, '0},
         '{fcr_pkg::CHAR_POINT, 1'b0, '0},
         '{8'h35, 1'b0, '0},
         '{fcr_pkg::END_BYTE_RST, 1'b0, '0},
         // unknown flag closes silently
         '{fcr_pkg::START_BYTE_RST, 1'b0, '0},
         '{8'h07, 1'b0, '0},
         '{fcr_pkg::END_BYTE_RST, 1'b0, '0}
      };

      cfg_start    = fcr_pkg::START_BYTE_RST;
      cfg_end      = fcr_pkg::END_BYTE_RST;
      cfg_dir      = fcr_pkg::DIRECTION_CODE_RST;
      cfg_angle    = fcr_pkg::ANGLE_CODE_RST;
      frame_state  = fcr_pkg::PH_START;
      stored_count = '0;
      flag_seen    = '0;
      first_byte   = '0;
      restart_number();

      repeat (5) @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);

      random_phase();
      apply_setting(8'h00, 8'hFF, 8'h00, 8'hFF);
      random_phase();
      apply_setting(8'hFF, 8'h00, 8'hFF, 8'h00);
      random_phase();
      // line feed as end byte, no idling on either side
      quiet = 1'b1;
      apply_setting(8'h7E, 8'h0A, 8'h44, 8'h41);
      random_phase();
      quiet = 1'b0;
      apply_setting(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
      random_phase();
      apply_setting(fcr_pkg::START_BYTE_RST, fcr_pkg::END_BYTE_RST,
                    fcr_pkg::DIRECTION_CODE_RST, fcr_pkg::ANGLE_CODE_RST);
      random_phase();

      @(negedge clock);
      req_valid <= 1'b0;
      while (expected_updates.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);

      $display("Sent %0d bytes over six register settings;", bytes_sent);
      $display("checked %0d direction and %0d angle updates.", direction_checked, angle_checked);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+hw/rtl
hw/rtl/fcr_pkg.sv
hw/rtl/framed_uart_command_receiver.sv
tb/tb.sv
